// ===== hw/rtl/exclusive_time_profiler_defines.svh =====
// assertion macros for the exclusive time profiler
`ifndef EXCLUSIVE_TIME_PROFILER_DEFINES_SVH
`define EXCLUSIVE_TIME_PROFILER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, checked on clk with reset masking
`define ETP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("etp check failed");

// next-cycle implication, checked on clk with reset masking
`define ETP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("etp check failed");

`else

`define ETP_ASSERT_IMP(lbl, ante, cons)
`define ETP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/etp_pkg.sv =====
// shared types and constants for the exclusive time profiler
package etp_pkg;

	localparam int MAX_FUNCTIONS_DEF = 256;
	localparam int STACK_DEPTH_DEF   = 64;
	localparam int TIME_BITS_DEF     = 32;

	localparam int ID_W = 8;
	localparam int TS_W = 32;
	localparam int NF_W = 9;

	localparam logic [NF_W-1:0] NF_RESET = 9'd256;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_END   = 2'd1,
		MODE_READ  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ERR_OK       = 2'd0,
		ERR_EMPTY    = 2'd1,
		ERR_OVERFLOW = 2'd2,
		ERR_RANGE    = 2'd3
	} err_t;

	typedef struct packed {
		mode_t            mode;
		logic [ID_W-1:0]  func_id;
		logic [TS_W-1:0]  timestamp;
	} cmd_t;

	typedef struct packed {
		logic             credited;
		logic [ID_W-1:0]  credited_id;
		logic [TS_W-1:0]  total_time;
		err_t             error;
	} res_t;

	typedef struct packed {
		logic id_we;
		logic rt_we;
	} stk_wr_t;

endpackage

// ===== hw/rtl/etp_stack.sv =====
// call stack memory: id and resume time per entry, per-field write enables
module etp_stack
	import etp_pkg::*;
#(
	parameter int DEPTH = STACK_DEPTH_DEF,
	parameter int TB    = TIME_BITS_DEF
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [ID_W-1:0]          rd_id,
	output logic [TB-1:0]            rd_rt,
	input  stk_wr_t                  wr,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [ID_W-1:0]          wr_id,
	input  logic [TB-1:0]            wr_rt
);

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [TB-1:0]   rt;
	} ent_t;

	ent_t mem_q [DEPTH];
	ent_t rd_q;

	always_ff @(posedge clk) begin
		if (wr.id_we) begin
			mem_q[waddr].id <= wr_id;
		end
		if (wr.rt_we) begin
			mem_q[waddr].rt <= wr_rt;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem_q[raddr];
	end

	assign rd_id = rd_q.id;
	assign rd_rt = rd_q.rt;

endmodule

// ===== hw/rtl/etp_totals.sv =====
// per-function total memory with a zeroing sweep after reset
module etp_totals
	import etp_pkg::*;
#(
	parameter int NUM = MAX_FUNCTIONS_DEF,
	parameter int TB  = TIME_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [$clog2(NUM)-1:0] raddr,
	output logic [TB-1:0]          rdata,
	input  logic                   we,
	input  logic [$clog2(NUM)-1:0] waddr,
	input  logic [TB-1:0]          wdata,
	output logic                   ready
);

	localparam int AW = $clog2(NUM);

	logic [TB-1:0] mem_q [NUM];
	logic [TB-1:0] rdata_q;
	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;

	logic          we_m;
	logic [AW-1:0] waddr_m;
	logic [TB-1:0] wdata_m;

	// sweep one entry per cycle until every total is zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == AW'(NUM - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (clr_q) begin
			we_m    = 1'b1;
			waddr_m = clr_cnt_q;
			wdata_m = '0;
		end else begin
			we_m    = we;
			waddr_m = waddr;
			wdata_m = wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we_m) begin
			mem_q[waddr_m] <= wdata_m;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
	assign ready = ~clr_q;

endmodule

// ===== hw/rtl/exclusive_time_profiler.sv =====
// exclusive time profiler top level: command sequencer and credit datapath
//
//  channel   direction  handshake              payload
//  command   in         start, busy            cmd (cmd_t)
//  result    out        done (one cycle)       res (res_t)
//  config    in         cfg_we                 cfg_wdata (num_functions)
//
// after each transfer busy stays high through states S_RD1 and S_RD2, and done
// pulses in the cycle after S_RD2 with the result; the states serve two
// dependent synchronous reads: the stack top first, then the totals entry,
// whose address on a start is the caller id held on the stack
// after reset the totals memory is zeroed one entry per cycle with busy high;
// config writes are taken during the sweep
// the result side cannot stall: a result lives on res for the done cycle only
module exclusive_time_profiler
	import etp_pkg::*;
#(
	parameter int MAX_FUNCTIONS = MAX_FUNCTIONS_DEF,
	parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
	parameter int TIME_BITS     = TIME_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  cmd_t            cmd,
	output logic            done,
	output res_t            res,
	input  logic            cfg_we,
	input  logic [NF_W-1:0] cfg_wdata
);

`include "exclusive_time_profiler_defines.svh"

	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int DW  = $clog2(STACK_DEPTH + 1);
	localparam int AW  = $clog2(MAX_FUNCTIONS);
	localparam int TB  = TIME_BITS;
	localparam logic [TB-1:0] TMAX = {TB{1'b1}};

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD1,
		S_RD2
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_PUSH,
		OP_POP,
		OP_READ
	} op_t;

	state_t          state_q;
	logic [NF_W-1:0] nf_q;
	logic [DW-1:0]   depth_q;
	op_t             op_q;
	err_t            err_q;
	logic [ID_W-1:0] id_q;
	logic [TB-1:0]   t_q;
	logic            done_q;
	res_t            res_q;

	// values captured while the stack top is on the read port
	logic            credit_s2;
	logic [ID_W-1:0] caller_s2;
	logic [TB-1:0]   delta_s2;
	logic [TB-1:0]   resume_s2;

	logic            accept;
	logic            tot_ready;
	logic            id_ok;
	logic            depth_nz;
	logic            full;
	op_t             op_d;
	err_t            err_d;

	logic [ID_W-1:0] stk_rd_id;
	logic [TB-1:0]   stk_rd_rt;
	stk_wr_t         stk_wr;
	logic [SAW-1:0]  stk_raddr;
	logic [SAW-1:0]  stk_waddr;
	logic [TB-1:0]   stk_wr_rt;

	logic [AW-1:0]   tot_raddr;
	logic [TB-1:0]   tot_rdata;
	logic            tot_we;
	logic [AW-1:0]   tot_waddr;

	logic [TB-1:0]   diff;
	logic            t_ge_r;
	logic [TB-1:0]   delta_d;
	logic            credit_d;
	logic [TB:0]     sum;
	logic [TB-1:0]   new_tot;
	res_t            res_d;

	assign busy   = (state_q != S_IDLE) | ~tot_ready;
	assign accept = start & ~busy;

	// command decode, checked against the live depth at the transfer
	assign id_ok    = ({1'b0, cmd.func_id} < nf_q) && (32'(cmd.func_id) < MAX_FUNCTIONS);
	assign depth_nz = (depth_q != '0);
	assign full     = (depth_q >= DW'(STACK_DEPTH));

	always_comb begin
		op_d  = OP_NONE;
		err_d = ERR_OK;
		priority if (cmd.mode == MODE_NONE) begin
			op_d  = OP_NONE;
			err_d = ERR_OK;
		end else if (!id_ok) begin
			err_d = ERR_RANGE;
		end else if (cmd.mode == MODE_START) begin
			if (full) begin
				err_d = ERR_OVERFLOW;
			end else begin
				op_d = OP_PUSH;
			end
		end else if (cmd.mode == MODE_END) begin
			if (!depth_nz) begin
				err_d = ERR_EMPTY;
			end else begin
				op_d = OP_POP;
			end
		end else begin
			op_d = OP_READ;
		end
	end

	// stack top is always read; it is only used when the depth is nonzero
	assign stk_raddr = SAW'(depth_q - DW'(1));

	etp_stack #(
		.DEPTH (STACK_DEPTH),
		.TB    (TB)
	) u_stack (
		.clk   (clk),
		.raddr (stk_raddr),
		.rd_id (stk_rd_id),
		.rd_rt (stk_rd_rt),
		.wr    (stk_wr),
		.waddr (stk_waddr),
		.wr_id (id_q),
		.wr_rt (stk_wr_rt)
	);

	// first read cycle: elapsed time against the top's resume time
	assign t_ge_r = (t_q >= stk_rd_rt);
	assign diff   = t_q - stk_rd_rt;

	always_comb begin
		delta_d  = '0;
		credit_d = 1'b0;
		unique case (op_q)
			OP_PUSH: begin
				delta_d  = t_ge_r ? diff : '0;
				credit_d = depth_nz && (32'(stk_rd_id) < MAX_FUNCTIONS);
			end
			OP_POP: begin
				// end events count both end points, saturating
				if (t_ge_r) begin
					delta_d = (diff == TMAX) ? TMAX : diff + TB'(1);
				end
				credit_d = 1'b1;
			end
			OP_READ, OP_NONE: begin
				delta_d  = '0;
				credit_d = 1'b0;
			end
			default: begin
				delta_d  = '0;
				credit_d = 1'b0;
			end
		endcase
	end

	// a start credits the caller found on the stack, the rest use the command id
	assign tot_raddr = (op_q == OP_PUSH) ? AW'(stk_rd_id) : AW'(id_q);

	etp_totals #(
		.NUM (MAX_FUNCTIONS),
		.TB  (TB)
	) u_totals (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (tot_raddr),
		.rdata  (tot_rdata),
		.we     (tot_we),
		.waddr  (tot_waddr),
		.wdata  (new_tot),
		.ready  (tot_ready)
	);

	// second read cycle: saturating accumulate and write back
	assign sum     = {1'b0, tot_rdata} + {1'b0, delta_s2};
	assign new_tot = sum[TB] ? TMAX : sum[TB-1:0];

	assign tot_we    = (state_q == S_RD2) && credit_s2 &&
	                   ((op_q == OP_PUSH) || (op_q == OP_POP));
	assign tot_waddr = (op_q == OP_PUSH) ? AW'(caller_s2) : AW'(id_q);

	// push writes the whole entry, pop refreshes the new top's resume time
	always_comb begin
		stk_wr    = '0;
		stk_waddr = SAW'(depth_q);
		stk_wr_rt = t_q;
		if (state_q == S_RD2) begin
			if (op_q == OP_PUSH) begin
				stk_wr.id_we = 1'b1;
				stk_wr.rt_we = 1'b1;
			end else if ((op_q == OP_POP) && (depth_q > DW'(1))) begin
				stk_wr.rt_we = 1'b1;
				stk_waddr    = SAW'(depth_q - DW'(2));
				stk_wr_rt    = resume_s2;
			end
		end
	end

	always_comb begin
		res_d       = '0;
		res_d.error = err_q;
		unique case (op_q)
			OP_READ: begin
				res_d.credited    = 1'b1;
				res_d.credited_id = id_q;
				res_d.total_time  = TS_W'(tot_rdata);
			end
			OP_PUSH: begin
				if (credit_s2) begin
					res_d.credited    = 1'b1;
					res_d.credited_id = caller_s2;
					res_d.total_time  = TS_W'(new_tot);
				end
			end
			OP_POP: begin
				res_d.credited    = 1'b1;
				res_d.credited_id = id_q;
				res_d.total_time  = TS_W'(new_tot);
			end
			OP_NONE: begin
				res_d.credited = 1'b0;
			end
			default: begin
				res_d.credited = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			nf_q      <= NF_RESET;
			depth_q   <= '0;
			op_q      <= OP_NONE;
			err_q     <= ERR_OK;
			id_q      <= '0;
			t_q       <= '0;
			credit_s2 <= 1'b0;
			caller_s2 <= '0;
			delta_s2  <= '0;
			resume_s2 <= '0;
			done_q    <= 1'b0;
			res_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				nf_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= op_d;
						err_q   <= err_d;
						id_q    <= cmd.func_id;
						t_q     <= TB'(cmd.timestamp);
						state_q <= S_RD1;
					end
				end
				S_RD1: begin
					credit_s2 <= credit_d;
					caller_s2 <= stk_rd_id;
					delta_s2  <= delta_d;
					resume_s2 <= (t_q == TMAX) ? TMAX : t_q + TB'(1);
					state_q   <= S_RD2;
				end
				S_RD2: begin
					if (op_q == OP_PUSH) begin
						depth_q <= depth_q + DW'(1);
					end else if (op_q == OP_POP) begin
						depth_q <= depth_q - DW'(1);
					end
					res_q   <= res_d;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

	`ETP_ASSERT_NXT(a_accept_busy, start && !busy, busy)
	`ETP_ASSERT_IMP(a_done_after_rd2, done, $past(state_q == S_RD2))
	`ETP_ASSERT_IMP(a_err_no_credit, done && (res.error != ERR_OK), !res.credited)
	`ETP_ASSERT_IMP(a_depth_bound, 1'b1, depth_q <= DW'(STACK_DEPTH))
	`ETP_ASSERT_NXT(a_pop_depth, (state_q == S_RD2) && (op_q == OP_POP), depth_q == $past(depth_q) - DW'(1))

endmodule

// ===== dv/exclusive_time_profiler_checker.sv =====
// checker for the exclusive time profiler: predicts each command's result and compares
module exclusive_time_profiler_checker
	import etp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  cmd_t            cmd,
	input  logic            done,
	input  res_t            res,
	input  logic            cfg_we,
	input  logic [NF_W-1:0] cfg_wdata,
	output int              mismatch_count,
	output int              outstanding,
	output int              results_checked
);

	localparam int CALL_DEPTH = 64;
	localparam int N_IDS      = 256;

	logic [NF_W-1:0] num_funcs;
	logic [ID_W-1:0] call_ids [CALL_DEPTH];
	logic [TS_W-1:0] resume_at [CALL_DEPTH];
	int              call_depth;
	logic [TS_W-1:0] excl_time [N_IDS];
	res_t            expected_results [$];
	res_t            oldest;
	int              fails;
	int              checked;

	function automatic logic [TS_W-1:0] add_sat(logic [TS_W-1:0] a, logic [TS_W-1:0] b);
		logic [TS_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TS_W] ? '1 : s[TS_W-1:0];
	endfunction

	// applies one command to the shadow call stack and totals, returns its result
	function automatic res_t profile_event(cmd_t c);
		res_t            r;
		logic [TS_W-1:0] elapsed;
		logic [TS_W-1:0] resumed;
		logic [ID_W-1:0] caller;
		r = '0;
		r.error = ERR_OK;
		if (c.mode == MODE_NONE)
			return r;
		// ids are 8 bits, so the table size bound is always met
		if ({1'b0, c.func_id} >= num_funcs) begin
			r.error = ERR_RANGE;
			return r;
		end
		case (c.mode)
			MODE_START: begin
				if (call_depth >= CALL_DEPTH) begin
					r.error = ERR_OVERFLOW;
					return r;
				end
				if (call_depth > 0) begin
					caller  = call_ids[call_depth-1];
					resumed = resume_at[call_depth-1];
					elapsed = (c.timestamp >= resumed) ? c.timestamp - resumed : '0;
					excl_time[caller] = add_sat(excl_time[caller], elapsed);
					r.credited    = 1'b1;
					r.credited_id = caller;
					r.total_time  = excl_time[caller];
				end
				call_ids[call_depth]  = c.func_id;
				resume_at[call_depth] = c.timestamp;
				call_depth++;
			end
			MODE_END: begin
				if (call_depth == 0) begin
					r.error = ERR_EMPTY;
					return r;
				end
				resumed = resume_at[call_depth-1];
				elapsed = (c.timestamp >= resumed) ? add_sat(c.timestamp - resumed, 1) : '0;
				excl_time[c.func_id] = add_sat(excl_time[c.func_id], elapsed);
				r.credited    = 1'b1;
				r.credited_id = c.func_id;
				r.total_time  = excl_time[c.func_id];
				call_depth--;
				if (call_depth > 0)
					resume_at[call_depth-1] = add_sat(c.timestamp, 1);
			end
			MODE_READ: begin
				r.credited    = 1'b1;
				r.credited_id = c.func_id;
				r.total_time  = excl_time[c.func_id];
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report(string field, logic [TS_W-1:0] want_v, logic [TS_W-1:0] got_v);
		fails++;
		$display("%0t %s mismatch: expected %0h, actual %0h", $time, field, want_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_funcs  = NF_RESET;
			call_depth = 0;
			foreach (excl_time[i])
				excl_time[i] = '0;
			expected_results.delete();
			fails   = 0;
			checked = 0;
			mismatch_count  <= 0;
			outstanding     <= 0;
			results_checked <= 0;
		end else begin
			// results first: a result in this cycle belongs to an earlier transfer
			if (done) begin
				if (expected_results.size() == 0) begin
					fails++;
					$display("%0t unexpected result %h with nothing pending", $time, res);
				end else begin
					oldest = expected_results.pop_front();
					checked++;
					if (res.credited !== oldest.credited)
						report("credited", oldest.credited, res.credited);
					if (res.credited_id !== oldest.credited_id)
						report("credited_id", oldest.credited_id, res.credited_id);
					if (res.total_time !== oldest.total_time)
						report("total_time", oldest.total_time, res.total_time);
					if (res.error !== oldest.error)
						report("error", oldest.error, res.error);
				end
			end
			if (cfg_we)
				num_funcs = cfg_wdata;
			if (start && !busy)
				expected_results.push_back(profile_event(cmd));
			mismatch_count  <= fails;
			outstanding     <= expected_results.size();
			results_checked <= checked;
		end
	end

endmodule

// ===== dv/tb_exclusive_time_profiler.sv =====
// testbench top for the exclusive time profiler: stimulus, pacing, watchdog and verdict
module tb_exclusive_time_profiler;
	import etp_pkg::*;

	// cycles with no transfer at all before the run is declared hung;
	// the slowest legal stretch is the clearing sweep after reset plus a gap
	localparam int IDLE_LIMIT = 2000;
	localparam int CALL_DEPTH = 64;
	localparam int N_PHASES   = 9;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            start     = 1'b0;
	logic            busy;
	cmd_t            cmd       = '0;
	logic            done;
	res_t            res;
	logic            cfg_we    = 1'b0;
	logic [NF_W-1:0] cfg_wdata = '0;

	int mismatch_count;
	int outstanding;
	int results_checked;
	int idle_cycles = 0;

	// stimulus-side view of the block, used only to shape well-formed call sequences
	logic [NF_W-1:0] active_funcs = NF_RESET;
	logic [ID_W-1:0] shadow_calls [$];
	logic [TS_W-1:0] clock_now    = '0;
	int              burst_left   = 0;
	bit              gaps_on      = 1'b1;
	int              n_start      = 0;
	int              n_end        = 0;
	int              n_read       = 0;
	int              n_ignored    = 0;
	int              deepest      = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	exclusive_time_profiler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	exclusive_time_profiler_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.done            (done),
		.res             (res),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.mismatch_count  (mismatch_count),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	// one command transfer; start stays high afterwards so back-to-back commands
	// go out without a bubble, and a gap only opens at the head of a new burst
	task automatic transfer(cmd_t c);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if (gaps_on && $urandom_range(0, 9) > 2) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
	endtask

	// issue a command and keep the stimulus-side call stack in step with it
	task automatic issue(mode_t m, logic [ID_W-1:0] id, logic [TS_W-1:0] ts);
		cmd_t c;
		logic in_range;
		c.mode      = m;
		c.func_id   = id;
		c.timestamp = ts;
		in_range    = {1'b0, id} < active_funcs;
		case (m)
			MODE_START: begin
				n_start++;
				if (in_range && shadow_calls.size() < CALL_DEPTH)
					shadow_calls.push_back(id);
			end
			MODE_END: begin
				n_end++;
				if (in_range && shadow_calls.size() > 0)
					shadow_calls.delete(shadow_calls.size() - 1);
			end
			MODE_READ: n_read++;
			default: n_ignored++;
		endcase
		if (shadow_calls.size() > deepest)
			deepest = shadow_calls.size();
		transfer(c);
	endtask

	// hold off until every command sent so far has its result back
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		burst_left = 0;
	endtask

	// the register may only change while the block is idle
	task automatic write_funcs(logic [NF_W-1:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		active_funcs = v;
		@(posedge clk);
	endtask

	function automatic logic [ID_W-1:0] pick_id();
		int lim;
		lim = (active_funcs > 256) ? 256 : int'(active_funcs);
		if (lim == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, lim - 1));
	endfunction

	// mostly small forward steps, now and then a jump anywhere or a step back
	function automatic logic [TS_W-1:0] next_time();
		int unsigned r;
		int unsigned step;
		r = $urandom_range(0, 99);
		if (r < 4)
			return clock_now - 32'($urandom_range(0, 50));
		if (r < 8) begin
			clock_now = $urandom();
			return clock_now;
		end
		step = $urandom_range(0, 40);
		clock_now = (clock_now > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : clock_now + step;
		return clock_now;
	endfunction

	// mostly well-formed call/return traffic, plus reads, noise and ignored commands
	task automatic random_item(int push_bias, output bit counts);
		int r;
		logic [ID_W-1:0] id;
		r = $urandom_range(0, 99);
		counts = 1'b1;
		if (r < 3) begin
			counts = 1'b0;
			issue(MODE_NONE, 8'($urandom_range(0, 255)), $urandom());
		end else if (r < 10) begin
			issue(MODE_READ, (r < 6) ? pick_id() : 8'($urandom_range(0, 255)), next_time());
		end else if (r < 16 || active_funcs == 0) begin
			issue(mode_t'($urandom_range(0, 2)), 8'($urandom_range(0, 255)), next_time());
		end else if (shadow_calls.size() == 0 || $urandom_range(0, 99) < push_bias) begin
			// on a full stack this is the overflow case
			issue(MODE_START, pick_id(), next_time());
		end else begin
			// return from the innermost call, sometimes naming another id
			id = shadow_calls[shadow_calls.size() - 1];
			if ({1'b0, id} >= active_funcs || $urandom_range(0, 19) == 0)
				id = pick_id();
			issue(MODE_END, id, next_time());
		end
	endtask

	initial begin : stimulus
		int funcs;
		int bias;
		int len;
		int got;
		bit counts;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// the totals table is swept clear after reset with busy high
		do @(posedge clk); while (busy);

		// directed: empty-stack end, a read at the highest id, ignored mode
		issue(MODE_END, 8'd0, 32'd0);
		issue(MODE_READ, 8'd255, 32'd0);
		issue(MODE_NONE, 8'hA5, 32'h5A5A_5A5A);
		// first start on an empty stack credits nobody
		issue(MODE_START, 8'd0, 32'd0);
		issue(MODE_START, 8'd255, 32'd10);
		// time going backwards counts as zero elapsed
		issue(MODE_END, 8'd255, 32'd0);
		issue(MODE_START, 8'h80, 32'hFFFF_FFFF);
		// end naming a different id than the top, resume saturates at all ones
		issue(MODE_END, 8'h7F, 32'hFFFF_FFFF);
		// pushes id 0's total past the top and saturates it
		issue(MODE_END, 8'd0, 32'hFFFF_FFFF);
		// whole time range in one call: elapsed plus one saturates
		issue(MODE_START, 8'd1, 32'd0);
		issue(MODE_END, 8'd1, 32'hFFFF_FFFF);
		issue(MODE_READ, 8'd1, 32'd0);
		issue(MODE_READ, 8'd0, 32'd0);
		// a single valid id
		write_funcs(9'd1);
		issue(MODE_START, 8'd1, 32'd5);
		issue(MODE_END, 8'd200, 32'd5);
		issue(MODE_START, 8'd0, 32'h5555_5555);
		issue(MODE_START, 8'd0, 32'hAAAA_AAAA);
		issue(MODE_END, 8'd0, 32'hAAAA_AAAF);
		issue(MODE_END, 8'd0, 32'hFFFF_FFF0);
		issue(MODE_READ, 8'd0, 32'd0);
		// no valid id at all
		write_funcs(9'd0);
		issue(MODE_READ, 8'd0, 32'd0);
		issue(MODE_START, 8'd0, 32'd0);

		// random phases, each under its own register value and call depth bias
		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: begin funcs = 256; bias = 55; len = 110; end
				1: begin funcs = 1;   bias = 50; len = 70;  end
				2: begin funcs = 0;   bias = 50; len = 15;  end
				3: begin funcs = 511; bias = 88; len = 130; end
				4: begin funcs = 7;   bias = 60; len = 100; end
				5: begin funcs = 256; bias = 92; len = 140; end
				6: begin funcs = $urandom_range(1, 511); bias = 55; len = 100; end
				7: begin funcs = 2;   bias = 50; len = 80;  end
				default: begin funcs = 300; bias = 45; len = 110; end
			endcase
			write_funcs(9'(funcs));
			gaps_on = !(p == 2 || p == 6);
			case ($urandom_range(0, 2))
				0: clock_now = '0;
				1: clock_now = 32'hFFFF_FF00;
				default: clock_now = $urandom();
			endcase
			got = 0;
			while (got < len) begin
				random_item(bias, counts);
				got += counts;
			end
		end

		settle();
		repeat (10) @(posedge clk);
		$display("profiler run: %0d starts, %0d ends, %0d reads, %0d ignored, %0d results checked",
			n_start, n_end, n_read, n_ignored, results_checked);
		$display("num_functions from 0 to 511 over %0d phases, call depth reached %0d of %0d",
			N_PHASES, deepest, CALL_DEPTH);
		if (mismatch_count == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog: any command or result transfer restarts the count
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
